// File: rtl/lshp_pkg.sv
// Package for the laser scan header parser: parse phases, wire/field codes,
// status codes and the result record type. No dependencies.
package lshp_pkg;

  typedef enum logic [2:0] {
    PH_TAG    = 3'd0,
    PH_VAR    = 3'd1,
    PH_LEN    = 3'd2,
    PH_FIX    = 3'd3,
    PH_SKIP   = 3'd4,
    PH_FRAME  = 3'd5,
    PH_PACKED = 3'd6,
    PH_STOP   = 3'd7
  } lshp_phase_e;

  localparam logic [2:0] WIRE_VARINT = 3'd0;
  localparam logic [2:0] WIRE_I64    = 3'd1;
  localparam logic [2:0] WIRE_LEN    = 3'd2;
  localparam logic [2:0] WIRE_I32    = 3'd5;

  localparam logic [28:0] FLD_TIMESTAMP = 29'd1;
  localparam logic [28:0] FLD_FRAME_ID  = 29'd2;
  localparam logic [28:0] FLD_START_ANG = 29'd4;
  localparam logic [28:0] FLD_END_ANG   = 29'd5;
  localparam logic [28:0] FLD_RANGES    = 29'd6;

  // inner timestamp fields
  localparam logic [28:0] TS_SECONDS = 29'd1;
  localparam logic [28:0] TS_NANOS   = 29'd2;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_BAD_WIRE  = 3'd1;
  localparam logic [2:0] ST_TRUNC     = 3'd2;
  localparam logic [2:0] ST_PACKED    = 3'd3;
  localparam logic [2:0] ST_VAR_LONG  = 3'd4;

  localparam logic       KIND_FRAME   = 1'b0;
  localparam logic       KIND_SUMMARY = 1'b1;

  localparam logic [3:0]  VARINT_MAX = 4'd10;
  localparam logic [29:0] NS_PER_S   = 30'd1000000000;

  typedef struct packed {
    logic        kind;
    logic [7:0]  frame_byte;
    logic        frame_start;
    logic [63:0] stamp_ns;
    logic [63:0] start_bits;
    logic [63:0] end_bits;
    logic [31:0] range_count;
    logic [2:0]  status;
  } lshp_rec_t;

  // up to two results per accepted byte, frame record first
  typedef struct packed {
    logic      vld0;
    logic      vld1;
    lshp_rec_t rec0;
    lshp_rec_t rec1;
  } lshp_push_t;

endpackage

// File: rtl/laser_scan_header_parser_core.sv
// Top level of the laser scan header parser: byte parser feeding a result
// queue. Depends on lshp_pkg, lshp_parser and lshp_resq.
//
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+------------------------------------
//  input    | in        | push / full        | in_byte_i, in_last_i
//  result   | out       | pop / empty        | res_kind_o, frame_byte_o, frame_start_o,
//           |           |                    | stamp_ns_o, start/end_angle_bits_o,
//           |           |                    | range_count_o, status_o
//
// One byte is decoded per cycle; a new byte may be pushed every cycle while
// the queue has two free entries. A result is queued in the cycle after the
// byte that caused it. The timestamp product is built per varint byte with one
// 7x30 multiply, so the single parser step sets the rate of one byte a cycle.
// Reset clears the parser and empties the queue; no clearing pass is needed.
// A stalled result side raises full once three of the four queue entries hold.
module laser_scan_header_parser_core #(
  parameter int COUNT_WIDTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  in_byte_i,
  input  logic        in_last_i,
  output logic        empty,
  input  logic        pop,
  output logic        res_kind_o,
  output logic [7:0]  frame_byte_o,
  output logic        frame_start_o,
  output logic signed [63:0] stamp_ns_o,
  output logic [63:0] start_angle_bits_o,
  output logic [63:0] end_angle_bits_o,
  output logic [31:0] range_count_o,
  output logic [2:0]  status_o
);
  import lshp_pkg::*;

  lshp_push_t push_w;
  lshp_rec_t  head_w;
  logic       take;

  // accept a request only when two queue entries are free
  assign take = push && !full;

  lshp_parser #(.COUNT_WIDTH(COUNT_WIDTH)) u_parser (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .take_i    (take),
    .in_byte_i (in_byte_i),
    .in_last_i (in_last_i),
    .push_o    (push_w)
  );

  lshp_resq u_resq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push_w),
    .pop_i   (pop),
    .full_o  (full),
    .empty_o (empty),
    .head_o  (head_w)
  );

  assign res_kind_o         = head_w.kind;
  assign frame_byte_o       = head_w.frame_byte;
  assign frame_start_o      = head_w.frame_start;
  assign stamp_ns_o         = head_w.stamp_ns;
  assign start_angle_bits_o = head_w.start_bits;
  assign end_angle_bits_o   = head_w.end_bits;
  assign range_count_o      = head_w.range_count;
  assign status_o           = head_w.status;

endmodule

// File: rtl/lshp_parser.sv
// Front part: decodes one message byte per accepted request and emits
// frame id and summary records. Depends on lshp_pkg.
module lshp_parser #(
  parameter int COUNT_WIDTH = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               take_i,
  input  logic [7:0]         in_byte_i,
  input  logic               in_last_i,
  output lshp_pkg::lshp_push_t push_o
);
  import lshp_pkg::*;

  localparam int SUM_W = ((COUNT_WIDTH > 32) ? COUNT_WIDTH : 32) + 1;
  localparam logic [SUM_W-1:0] CNT_MAX = SUM_W'({COUNT_WIDTH{1'b1}});

  lshp_phase_e ph_q, ph_d;
  logic [63:0] acc_q, acc_d, prod_q, prod_d;
  logic [3:0]  vb_q, vb_d;
  logic [28:0] fn_q, fn_d;
  logic [2:0]  wk_q, wk_d;
  logic [31:0] bl_q, bl_d, sub_q, sub_d;
  logic        in_ts_q, in_ts_d;
  logic [63:0] secs_q, secs_d;
  logic [31:0] nanos_q, nanos_d;
  logic [63:0] ts_q, ts_d, sa_q, sa_d, ea_q, ea_d;
  logic [COUNT_WIDTH-1:0] rng_q, rng_d;
  logic [2:0]  err_q, err_d;

  logic [6:0]  b7;
  logic [63:0] var_term, prod_term, fix_term;
  logic [SUM_W-1:0] sum_one, sum_pk;
  logic [COUNT_WIDTH-1:0] rng_one, rng_pk;
  logic [31:0] len, tag;
  logic [3:0]  vb_inc;
  logic        vdone, vlong;
  logic [63:0] rng64;
  logic [2:0]  st;

  assign b7        = in_byte_i[6:0];
  assign var_term  = 64'(b7) << (7 * 32'(vb_q));
  assign prod_term = 64'(37'(b7) * 37'(NS_PER_S)) << (7 * 32'(vb_q));
  assign fix_term  = 64'(in_byte_i) << (8 * 32'(vb_q[2:0]));

  // saturating range counts, one for an unpacked record, one for a packed run
  assign sum_one = SUM_W'(rng_q) + SUM_W'(1);
  assign sum_pk  = SUM_W'(rng_q) + SUM_W'(acc_q[28:0]);
  assign rng_one = (sum_one > CNT_MAX) ? '1 : sum_one[COUNT_WIDTH-1:0];
  assign rng_pk  = (sum_pk > CNT_MAX) ? '1 : sum_pk[COUNT_WIDTH-1:0];

  always_comb begin
    ph_d = ph_q; acc_d = acc_q; prod_d = prod_q; vb_d = vb_q; fn_d = fn_q;
    wk_d = wk_q; bl_d = bl_q; sub_d = sub_q; in_ts_d = in_ts_q;
    secs_d = secs_q; nanos_d = nanos_q; ts_d = ts_q; sa_d = sa_q; ea_d = ea_q;
    rng_d = rng_q; err_d = err_q;
    push_o = '0;
    vb_inc = vb_q + 4'd1;
    vdone = 1'b0; vlong = 1'b0;
    len = 32'd0; tag = 32'd0; st = ST_OK; rng64 = 64'd0;

    if (take_i) begin
      if (ph_q != PH_STOP) begin
        if (in_ts_q && sub_q != 32'd0) sub_d = sub_q - 32'd1;
        case (ph_q)
          PH_TAG, PH_VAR, PH_LEN: begin
            if (vb_q < VARINT_MAX) begin
              acc_d  = acc_q | var_term;
              prod_d = prod_q + prod_term;
            end
            vb_d  = vb_inc;
            vdone = !in_byte_i[7];
            vlong = in_byte_i[7] && (vb_inc >= VARINT_MAX);
            len   = acc_d[31:0];
            tag   = acc_d[31:0];
            if (vlong) begin
              err_d = ST_VAR_LONG; ph_d = PH_STOP;
            end else if (vdone) begin
              if (ph_q == PH_TAG) begin
                fn_d = tag[31:3];
                wk_d = tag[2:0];
                if (tag == 32'd0) begin
                  if (in_ts_q) begin
                    ts_d = secs_d + {{32{nanos_d[31]}}, nanos_d};
                    in_ts_d = 1'b0;
                    acc_d = '0; prod_d = '0; vb_d = '0; ph_d = PH_TAG;
                  end else begin
                    ph_d = PH_STOP;
                  end
                end else begin
                  acc_d = '0; prod_d = '0; vb_d = '0;
                  case (tag[2:0])
                    WIRE_VARINT: ph_d = PH_VAR;
                    WIRE_I64: begin bl_d = 32'd8; ph_d = PH_FIX; end
                    WIRE_LEN:    ph_d = PH_LEN;
                    WIRE_I32: begin bl_d = 32'd4; ph_d = PH_FIX; end
                    default: begin err_d = ST_BAD_WIRE; ph_d = PH_STOP; end
                  endcase
                end
              end else if (ph_q == PH_VAR) begin
                if (in_ts_q) begin
                  if (fn_q == TS_SECONDS) secs_d = prod_d;
                  else if (fn_q == TS_NANOS) nanos_d = acc_d[31:0];
                end
                acc_d = '0; prod_d = '0; vb_d = '0; ph_d = PH_TAG;
              end else begin
                // length prefix done: pick the consumer of the payload
                acc_d = '0; prod_d = '0; vb_d = '0; ph_d = PH_TAG;
                if (in_ts_q) begin
                  if (len > sub_d) begin
                    err_d = ST_TRUNC; ph_d = PH_STOP;
                  end else if (len != 32'd0) begin
                    bl_d = len; ph_d = PH_SKIP;
                  end
                end else if (fn_q == FLD_TIMESTAMP) begin
                  in_ts_d = 1'b1; sub_d = len; secs_d = '0; nanos_d = '0;
                end else if (fn_q == FLD_FRAME_ID) begin
                  if (len != 32'd0) begin
                    bl_d = len; ph_d = PH_FRAME;
                  end
                end else if (fn_q == FLD_RANGES) begin
                  if (len[2:0] != 3'd0) begin
                    err_d = ST_PACKED; ph_d = PH_STOP;
                  end else if (len != 32'd0) begin
                    bl_d = len; acc_d = 64'(len[31:3]); ph_d = PH_PACKED;
                  end
                end else if (len != 32'd0) begin
                  bl_d = len; ph_d = PH_SKIP;
                end
              end
            end
          end
          PH_FIX: begin
            acc_d = acc_q | fix_term;
            vb_d  = vb_inc;
            bl_d  = bl_q - 32'd1;
            if (bl_d == 32'd0) begin
              if (!in_ts_q && wk_q == WIRE_I64) begin
                if (fn_q == FLD_START_ANG) sa_d = acc_d;
                else if (fn_q == FLD_END_ANG) ea_d = acc_d;
                else if (fn_q == FLD_RANGES) rng_d = rng_one;
              end
              acc_d = '0; prod_d = '0; vb_d = '0; ph_d = PH_TAG;
            end
          end
          PH_SKIP: begin
            bl_d = bl_q - 32'd1;
            if (bl_d == 32'd0) begin
              acc_d = '0; prod_d = '0; vb_d = '0; ph_d = PH_TAG;
            end
          end
          PH_FRAME: begin
            push_o.vld0 = 1'b1;
            push_o.rec0.kind = KIND_FRAME;
            push_o.rec0.frame_byte = in_byte_i;
            push_o.rec0.frame_start = (vb_q == 4'd0);
            vb_d = 4'd1;
            bl_d = bl_q - 32'd1;
            if (bl_d == 32'd0) begin
              acc_d = '0; prod_d = '0; vb_d = '0; ph_d = PH_TAG;
            end
          end
          PH_PACKED: begin
            bl_d = bl_q - 32'd1;
            if (bl_d == 32'd0) begin
              rng_d = rng_pk;
              acc_d = '0; prod_d = '0; vb_d = '0; ph_d = PH_TAG;
            end
          end
          default: ;
        endcase
        // submessage length used up
        if (ph_d != PH_STOP && in_ts_d && sub_d == 32'd0) begin
          if (ph_d == PH_TAG) begin
            ts_d = secs_d + {{32{nanos_d[31]}}, nanos_d};
            in_ts_d = 1'b0;
            acc_d = '0; prod_d = '0; vb_d = '0;
          end else begin
            err_d = ST_TRUNC; ph_d = PH_STOP;
          end
        end
      end

      if (in_last_i) begin
        if (ph_d == PH_STOP) begin
          st = err_d;
        end else if (ph_d == PH_TAG) begin
          if (in_ts_d) ts_d = secs_d + {{32{nanos_d[31]}}, nanos_d};
          st = ST_OK;
        end else begin
          st = ST_TRUNC;
        end
        rng64 = 64'(rng_d);
        if (push_o.vld0) begin
          push_o.vld1 = 1'b1;
          push_o.rec1.kind = KIND_SUMMARY;
          push_o.rec1.stamp_ns = ts_d;
          push_o.rec1.start_bits = sa_d;
          push_o.rec1.end_bits = ea_d;
          push_o.rec1.range_count = (rng64 > 64'hFFFF_FFFF) ? '1 : rng64[31:0];
          push_o.rec1.status = st;
        end else begin
          push_o.vld0 = 1'b1;
          push_o.rec0.kind = KIND_SUMMARY;
          push_o.rec0.stamp_ns = ts_d;
          push_o.rec0.start_bits = sa_d;
          push_o.rec0.end_bits = ea_d;
          push_o.rec0.range_count = (rng64 > 64'hFFFF_FFFF) ? '1 : rng64[31:0];
          push_o.rec0.status = st;
        end
        // back to reset state for the next message
        ph_d = PH_TAG; acc_d = '0; prod_d = '0; vb_d = '0; fn_d = '0; wk_d = '0;
        bl_d = '0; sub_d = '0; in_ts_d = 1'b0; secs_d = '0; nanos_d = '0;
        ts_d = '0; sa_d = '0; ea_d = '0; rng_d = '0; err_d = ST_OK;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q <= PH_TAG; acc_q <= '0; prod_q <= '0; vb_q <= '0; fn_q <= '0; wk_q <= '0;
      bl_q <= '0; sub_q <= '0; in_ts_q <= 1'b0; secs_q <= '0; nanos_q <= '0;
      ts_q <= '0; sa_q <= '0; ea_q <= '0; rng_q <= '0; err_q <= ST_OK;
    end else begin
      ph_q <= ph_d; acc_q <= acc_d; prod_q <= prod_d; vb_q <= vb_d; fn_q <= fn_d;
      wk_q <= wk_d; bl_q <= bl_d; sub_q <= sub_d; in_ts_q <= in_ts_d;
      secs_q <= secs_d; nanos_q <= nanos_d; ts_q <= ts_d; sa_q <= sa_d;
      ea_q <= ea_d; rng_q <= rng_d; err_q <= err_d;
    end
  end

endmodule

// File: rtl/lshp_resq.sv
// Back part: four-entry result queue taking up to two records a cycle and
// handing out one per pop. Depends on lshp_pkg.
module lshp_resq (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  lshp_pkg::lshp_push_t push_i,
  input  logic                 pop_i,
  output logic                 full_o,
  output logic                 empty_o,
  output lshp_pkg::lshp_rec_t  head_o
);
  import lshp_pkg::*;

  lshp_rec_t  mem_q [4];
  logic [1:0] wp_q, wp_d, rp_q, rp_d;
  logic [2:0] cnt_q, cnt_d;
  logic       do_pop;

  assign empty_o = (cnt_q == 3'd0);
  // hold back when fewer than two entries are free
  assign full_o  = (cnt_q > 3'd2);
  assign head_o  = mem_q[rp_q];
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wp_d  = wp_q + 2'(push_i.vld0) + 2'(push_i.vld1);
    rp_d  = rp_q + 2'(do_pop);
    cnt_d = cnt_q + 3'(push_i.vld0) + 3'(push_i.vld1) - 3'(do_pop);
  end

  always_ff @(posedge clk_i) begin
    if (push_i.vld0) mem_q[wp_q] <= push_i.rec0;
    if (push_i.vld1) mem_q[wp_q + 2'd1] <= push_i.rec1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0; rp_q <= '0; cnt_q <= '0;
    end else begin
      wp_q <= wp_d; rp_q <= rp_d; cnt_q <= cnt_d;
    end
  end

endmodule
